@@ hw/rtl/msort_pkg.sv @@
`default_nettype none

package msort_pkg;

    // Buffer codes: the load always fills buffer zero, and each merge pass
    // reads one buffer and writes the other.
    localparam logic BUF_0 = 1'b0;
    localparam logic BUF_1 = 1'b1;

    // Handoff from the sequencer to the output register. When valid is set,
    // the read data of the source buffer is one sorted word.
    typedef struct packed {
        logic valid;
        logic last;
        logic overflow;
    } emit_tag_t;

endpackage

`default_nettype wire

@@ hw/rtl/msort_ram.sv @@
`default_nettype none

module msort_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

@@ hw/rtl/msort_ctrl.sv @@
`default_nettype none

module msort_ctrl #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic signed [DATA_WIDTH-1:0]    in_value,
    input  wire logic                            in_last,
    input  wire logic signed [DATA_WIDTH-1:0]    rd_data,
    input  wire logic                            out_accept,
    output logic             [$clog2(DEPTH)-1:0] rd_addr,
    output logic                                 wr_en0,
    output logic                                 wr_en1,
    output logic             [$clog2(DEPTH)-1:0] wr_addr,
    output logic signed      [DATA_WIDTH-1:0]    wr_data,
    output logic                                 src_sel,
    output msort_pkg::emit_tag_t                 emit
);

    import msort_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int AW = $clog2(DEPTH + 1);
    localparam int PW = AW + 2;

    typedef enum logic [3:0] {
        S_LOAD,
        S_PASS,
        S_RUN,
        S_INIT_A,
        S_CAP_A,
        S_CAP_B,
        S_MERGE,
        S_EMIT_RD,
        S_EMIT_CAP,
        S_EMIT_WAIT
    } state_t;

    state_t                  state_reg, state_next;
    logic [AW-1:0]           cnt_reg, cnt_next;
    logic                    ovf_reg, ovf_next;
    logic                    src_reg, src_next;
    logic [PW-1:0]           width_reg, width_next;
    logic [PW-1:0]           lo_reg, lo_next;
    logic [PW-1:0]           mid_reg, mid_next;
    logic [PW-1:0]           hi_reg, hi_next;
    logic [PW-1:0]           a_reg, a_next;
    logic [PW-1:0]           b_reg, b_next;
    logic [PW-1:0]           k_reg, k_next;
    logic                    av_reg, av_next;
    logic                    bv_reg, bv_next;
    logic signed [DATA_WIDTH-1:0] a_val_reg, a_val_next;
    logic signed [DATA_WIDTH-1:0] b_val_reg, b_val_next;

    logic [PW-1:0] cnt_ext;
    logic [PW-1:0] sum_mid;
    logic [PW-1:0] sum_hi;
    logic [PW-1:0] mid_c;
    logic [PW-1:0] a_inc;
    logic [PW-1:0] b_inc;
    logic [PW-1:0] k_inc;
    logic          take_a;
    logic          wr_en;

    always_comb
    begin
        cnt_ext = PW'(cnt_reg);
        sum_mid = lo_reg + width_reg;
        sum_hi  = lo_reg + (width_reg << 1);
        mid_c   = (sum_mid > cnt_ext) ? cnt_ext : sum_mid;
        a_inc   = a_reg + PW'(1);
        b_inc   = b_reg + PW'(1);
        k_inc   = k_reg + PW'(1);
        take_a  = av_reg && (!bv_reg || (a_val_reg <= b_val_reg));

        state_next = state_reg;
        cnt_next   = cnt_reg;
        ovf_next   = ovf_reg;
        src_next   = src_reg;
        width_next = width_reg;
        lo_next    = lo_reg;
        mid_next   = mid_reg;
        hi_next    = hi_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        k_next     = k_reg;
        av_next    = av_reg;
        bv_next    = bv_reg;
        a_val_next = a_val_reg;
        b_val_next = b_val_reg;

        in_ready = 1'b0;
        rd_addr  = '0;
        wr_en    = 1'b0;
        wr_en0   = 1'b0;
        wr_en1   = 1'b0;
        wr_addr  = '0;
        wr_data  = '0;
        emit     = '0;

        unique case (state_reg)
            S_LOAD:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (cnt_reg < AW'(DEPTH))
                    begin
                        wr_en0   = 1'b1;
                        wr_addr  = cnt_reg[IW-1:0];
                        wr_data  = in_value;
                        cnt_next = cnt_reg + AW'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (in_last)
                    begin
                        width_next = PW'(1);
                        src_next   = BUF_0;
                        state_next = S_PASS;
                    end
                end
            end

            S_PASS:
            begin
                if (width_reg < cnt_ext)
                begin
                    lo_next    = '0;
                    state_next = S_RUN;
                end
                else
                begin
                    k_next     = '0;
                    state_next = S_EMIT_RD;
                end
            end

            S_RUN:
            begin
                if (lo_reg < cnt_ext)
                begin
                    mid_next   = mid_c;
                    hi_next    = (sum_hi > cnt_ext) ? cnt_ext : sum_hi;
                    a_next     = lo_reg;
                    b_next     = mid_c;
                    k_next     = lo_reg;
                    av_next    = 1'b0;
                    bv_next    = 1'b0;
                    rd_addr    = lo_reg[IW-1:0];
                    state_next = S_INIT_A;
                end
                else
                begin
                    src_next   = ~src_reg;
                    width_next = width_reg << 1;
                    state_next = S_PASS;
                end
            end

            S_INIT_A:
            begin
                a_val_next = rd_data;
                av_next    = 1'b1;
                if (b_reg < hi_reg)
                begin
                    rd_addr    = b_reg[IW-1:0];
                    state_next = S_CAP_B;
                end
                else
                begin
                    state_next = S_MERGE;
                end
            end

            S_CAP_A:
            begin
                a_val_next = rd_data;
                av_next    = 1'b1;
                state_next = S_MERGE;
            end

            S_CAP_B:
            begin
                b_val_next = rd_data;
                bv_next    = 1'b1;
                state_next = S_MERGE;
            end

            S_MERGE:
            begin
                if (!av_reg && !bv_reg)
                begin
                    lo_next    = sum_hi;
                    state_next = S_RUN;
                end
                else
                begin
                    wr_en   = 1'b1;
                    wr_addr = k_reg[IW-1:0];
                    wr_data = take_a ? a_val_reg : b_val_reg;
                    k_next  = k_inc;
                    if (take_a)
                    begin
                        a_next  = a_inc;
                        av_next = 1'b0;
                        if (a_inc < mid_reg)
                        begin
                            rd_addr    = a_inc[IW-1:0];
                            state_next = S_CAP_A;
                        end
                    end
                    else
                    begin
                        b_next  = b_inc;
                        bv_next = 1'b0;
                        if (b_inc < hi_reg)
                        begin
                            rd_addr    = b_inc[IW-1:0];
                            state_next = S_CAP_B;
                        end
                    end
                end
            end

            S_EMIT_RD:
            begin
                rd_addr    = k_reg[IW-1:0];
                state_next = S_EMIT_CAP;
            end

            S_EMIT_CAP:
            begin
                emit.valid    = 1'b1;
                emit.last     = (k_inc == cnt_ext);
                emit.overflow = ovf_reg;
                state_next    = S_EMIT_WAIT;
            end

            S_EMIT_WAIT:
            begin
                if (out_accept)
                begin
                    if (k_inc == cnt_ext)
                    begin
                        cnt_next   = '0;
                        ovf_next   = 1'b0;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        k_next     = k_inc;
                        state_next = S_EMIT_RD;
                    end
                end
            end

            default:
            begin
                state_next = S_LOAD;
            end
        endcase

        // Merge passes write the buffer that is not being read.
        if (wr_en)
        begin
            wr_en0 = (src_reg == BUF_1);
            wr_en1 = (src_reg == BUF_0);
        end
        src_sel = src_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            cnt_reg   <= '0;
            ovf_reg   <= 1'b0;
            src_reg   <= BUF_0;
            width_reg <= '0;
            lo_reg    <= '0;
            mid_reg   <= '0;
            hi_reg    <= '0;
            a_reg     <= '0;
            b_reg     <= '0;
            k_reg     <= '0;
            av_reg    <= 1'b0;
            bv_reg    <= 1'b0;
            a_val_reg <= '0;
            b_val_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ovf_reg   <= ovf_next;
            src_reg   <= src_next;
            width_reg <= width_next;
            lo_reg    <= lo_next;
            mid_reg   <= mid_next;
            hi_reg    <= hi_next;
            a_reg     <= a_next;
            b_reg     <= b_next;
            k_reg     <= k_next;
            av_reg    <= av_next;
            bv_reg    <= bv_next;
            a_val_reg <= a_val_next;
            b_val_reg <= b_val_next;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/merge_sorter_unit.sv @@
// Stable ascending sorter for sets of up to DEPTH signed words.
// Input channel (in_valid/in_ready, in_value, in_last): one word is taken per
// cycle while the block is loading. The word with in_last set closes the set.
// Words beyond DEPTH are dropped and the set is marked as overflowed; a
// dropped word that carries in_last still closes the set.
// After the set closes, in_ready stays low while a bottom-up merge sort runs
// over two ping-pong buffer memories of one read and one write port each.
// Each pass of the sort does one memory read per merged word; a set of n
// words takes ceil(log2 n) passes.
// Output channel (out_valid/out_ready, out_value, out_last, overflow): the
// sorted words leave through a registered output one at a time: each word
// is read, captured and handed off, and the next is read once it is taken.
// out_last marks the final word and overflow is the same on every word of
// the set. A stalled receiver simply holds the current word; the sort state
// waits without loss. Once the final word is taken, the block returns to
// loading. Reset clears the control state; the buffers need no clearing
// because every entry is written before it is read.
`default_nettype none

module merge_sorter_unit #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic signed [DATA_WIDTH-1:0] in_value,
    input  wire logic                         in_last,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic signed      [DATA_WIDTH-1:0] out_value,
    output logic                              out_last,
    output logic                              overflow
);

    import msort_pkg::*;

    localparam int IW = $clog2(DEPTH);

    logic [IW-1:0]                rd_addr;
    logic                         wr_en0;
    logic                         wr_en1;
    logic [IW-1:0]                wr_addr;
    logic signed [DATA_WIDTH-1:0] wr_data;
    logic                         src_sel;
    logic [DATA_WIDTH-1:0]        rd_data0;
    logic [DATA_WIDTH-1:0]        rd_data1;
    logic signed [DATA_WIDTH-1:0] rd_data;
    emit_tag_t                    emit;
    logic                         out_accept;

    logic                         out_valid_reg, out_valid_next;
    logic signed [DATA_WIDTH-1:0] out_value_reg, out_value_next;
    logic                         out_last_reg, out_last_next;
    logic                         overflow_reg, overflow_next;

    // Both buffers see the same read address; the sequencer says which one
    // currently holds the source runs.
    msort_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_buf0 (
        .clk     (clk),
        .wr_en   (wr_en0),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data0)
    );

    msort_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_buf1 (
        .clk     (clk),
        .wr_en   (wr_en1),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data1)
    );

    assign rd_data    = (src_sel == BUF_1) ? rd_data1 : rd_data0;
    assign out_accept = out_valid_reg && out_ready;

    msort_ctrl #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_value   (in_value),
        .in_last    (in_last),
        .rd_data    (rd_data),
        .out_accept (out_accept),
        .rd_addr    (rd_addr),
        .wr_en0     (wr_en0),
        .wr_en1     (wr_en1),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .src_sel    (src_sel),
        .emit       (emit)
    );

    // Output register: loaded when the sequencer hands over a sorted word,
    // released when the receiver takes it.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_value_next = out_value_reg;
        out_last_next  = out_last_reg;
        overflow_next  = overflow_reg;
        if (emit.valid)
        begin
            out_valid_next = 1'b1;
            out_value_next = rd_data;
            out_last_next  = emit.last;
            overflow_next  = emit.overflow;
        end
        else if (out_accept)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_value_reg <= '0;
            out_last_reg  <= 1'b0;
            overflow_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            out_value_reg <= out_value_next;
            out_last_reg  <= out_last_next;
            overflow_reg  <= overflow_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;
    assign out_last  = out_last_reg;
    assign overflow  = overflow_reg;

endmodule

`default_nettype wire
